>>> rtl/fqs_pkg.sv
// Shared types and constants for the FIFO queue with search.
// No dependencies; imported by fqs_ram and fifo_queue_with_search_top.
`timescale 1ns / 1ps

package fqs_pkg;

   localparam int FQS_DEPTH     = 128;
   localparam int FQS_WORD_BITS = 32;
   localparam int CAP_BITS      = 8;
   localparam int COUNT_BITS    = 8;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 8'd100;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 48;

   typedef enum logic [2:0] {
      MODE_ENQUEUE  = 3'd0,
      MODE_DEQUEUE  = 3'd1,
      MODE_PEEK     = 3'd2,
      MODE_CONTAINS = 3'd3,
      MODE_CLEAR    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

endpackage

>>> rtl/fqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on fqs_pkg for its default sizes.
`timescale 1ns / 1ps

module fqs_ram
   import fqs_pkg::*;
#(
   parameter int WIDTH = FQS_WORD_BITS,
   parameter int DEPTH = FQS_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fifo_queue_with_search_top.sv
// FIFO queue of unsigned 32-bit words with a programmable fullness limit and a search operation.
// Depends on fqs_pkg and fqs_ram.
`timescale 1ns / 1ps

// Each request transfer carries one operation and returns exactly one response
// transfer. Enqueue, clear, unused modes and dequeue or peek on an empty queue
// load their response from the idle state. Dequeue and peek of a held entry pass
// through ST_READ, as the entry store is a RAM with a registered read port.
// Contains reads the held entries from the oldest onwards, one per cycle through
// the single read port, and stops at the first match or after the last entry; on
// an empty queue it responds from the idle state.
// A new request is taken only once the previous response has been taken or is
// being taken in the same cycle. The user must write the capacity limit through
// the csr port only while the block is idle; the block does not enforce this. A
// limit above DEPTH acts as DEPTH and a limit of zero rejects every enqueue. No
// clearing pass is needed after reset.

module fifo_queue_with_search_top
   import fqs_pkg::*;
#(
   parameter int DEPTH = FQS_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // csr port: capacity limit
   input  logic                      csr_wr_en,
   input  logic [CAP_BITS-1:0]       csr_wr_data,
   // Request stream. tdata: mode [2:0], value [34:3], zero [39:35].
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // Response stream. tdata: status [1:0], data [33:2], found [34],
   // entry_count [42:35], is_empty [43], is_full [44], zero [47:45].
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   state_type state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;
   logic [FQS_WORD_BITS-1:0] value_ff, value_in;
   logic [CAP_BITS-1:0] cap_ff;
   logic rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                     ram_wr_en;
   logic [PTR_W-1:0]         ram_wr_addr;
   logic                     ram_rd_en;
   logic [PTR_W-1:0]         ram_rd_addr;
   logic [FQS_WORD_BITS-1:0] ram_rd_data;

   mode_type                 req_mode;
   logic [FQS_WORD_BITS-1:0] req_value;
   logic                     rsp_free;
   logic                     rsp_load;
   logic                     full_now;
   status_type               res_status;
   logic [FQS_WORD_BITS-1:0] res_data;
   logic                     res_found;
   logic [CNT_W-1:0]         res_count;
   logic                     res_empty;
   logic                     res_full;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign req_mode  = mode_type'(req_tdata[2:0]);
   assign req_value = req_tdata[FQS_WORD_BITS+2:3];
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign full_now  = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (CMP_W'(count_ff) >= DEPTH_CMP);

   fqs_ram #(
      .WIDTH (FQS_WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      value_in     = value_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;
      rsp_load     = 1'b0;
      res_status   = STATUS_OK;
      res_data     = '0;
      res_found    = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = rsp_free;
            if (req_tvalid && rsp_free) begin
               value_in = req_value;
               unique case (req_mode)
                  MODE_ENQUEUE: begin
                     rsp_load = 1'b1;
                     if (full_now) begin
                        res_status = STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        tail_in   = next_ptr(tail_ff);
                        count_in  = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  MODE_DEQUEUE, MODE_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_load   = 1'b1;
                        res_status = STATUS_EMPTY;
                        res_data   = '1;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_READ;
                        if (req_mode == MODE_DEQUEUE) begin
                           head_in  = next_ptr(head_ff);
                           count_in = CNT_W'(count_ff - 1'b1);
                        end
                     end
                  end
                  MODE_CONTAINS: begin
                     if (count_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        ram_rd_en    = 1'b1;
                        scan_ptr_in  = next_ptr(head_ff);
                        scan_left_in = CNT_W'(count_ff - 1'b1);
                        state_in     = ST_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     rsp_load = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            res_data = ram_rd_data;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // Each cycle compares the entry read in the previous cycle and,
            // unless the search is over, reads the next one.
            if (ram_rd_data == value_ff) begin
               rsp_load  = 1'b1;
               res_found = 1'b1;
               state_in  = ST_IDLE;
            end else if (scan_left_ff == '0) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = scan_ptr_ff;
               scan_ptr_in  = next_ptr(scan_ptr_ff);
               scan_left_in = CNT_W'(scan_left_ff - 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_count = count_in;
      res_empty = (res_count == '0);
      res_full  = (CMP_W'(res_count) >= CMP_W'(cap_ff)) || (CMP_W'(res_count) >= DEPTH_CMP);

      rsp_tdata_in = '0;
      rsp_tdata_in[1:0]   = res_status;
      rsp_tdata_in[33:2]  = res_data;
      rsp_tdata_in[34]    = res_found;
      rsp_tdata_in[42:35] = COUNT_BITS'(res_count);
      rsp_tdata_in[43]    = res_empty;
      rsp_tdata_in[44]    = res_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      value_ff     <= value_in;
      if (rsp_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
